// ----- hw/rtl/trlb_pkg.sv -----
// Package: shared constants and types for the texture residency tracker.
`default_nettype none
package trlb_pkg;
   localparam int unsigned ENTRIES_DEFAULT = 256;
   localparam int unsigned IDX_W = 8;
   localparam int unsigned BYTES_W = 27;
   localparam int unsigned TIME_W = 32;
   localparam int unsigned TOTAL_W = 32;
   localparam int unsigned CNT_W = 9;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_USE    = 2'd1;
   localparam logic [1:0] OP_LOAD   = 2'd2;
   localparam logic [1:0] OP_UNLOAD = 2'd3;

   localparam logic [CSR_ADDR_W-1:0] REG_HIGH_WM   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_LOW_WM    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_LIM_MOV   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_LIM_STILL = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_TO_MOV    = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_TO_STILL  = 3'd5;

   typedef struct packed {
      logic [1:0]         operation;
      logic [IDX_W-1:0]   entry_index;
      logic [BYTES_W-1:0] entry_bytes;
      logic               load_ok;
      logic               make_resident;
      logic               camera_moving;
      logic [15:0]        elapsed_ms;
      logic [TIME_W-1:0]  now_time;
   } req_type;

   typedef struct packed {
      logic               granted;
      logic               fallback;
      logic               loaded_now;
      logic [7:0]         evicted_count;
      logic [TOTAL_W-1:0] used_bytes;
      logic [CNT_W-1:0]   resident_count;
   } rsp_type;

   typedef struct packed {
      logic [CSR_ADDR_W-1:0] index;
      logic [CSR_DATA_W-1:0] data;
   } csr_type;
endpackage
`default_nettype wire

// ----- hw/rtl/trlb_if.sv -----
// Interfaces: valid/ready channels for requests, results and register writes.
`default_nettype none
interface trlb_req_if;
   import trlb_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface trlb_rsp_if;
   import trlb_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface trlb_csr_if;
   import trlb_pkg::*;
   logic    valid;
   logic    ready;
   csr_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/trlb_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module trlb_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- hw/rtl/texture_residency_lru_budget.sv -----
// Top level: residency table with load throttling and LRU eviction between watermarks.
`default_nettype none
// After reset a clearing pass marks every entry loadable; no item is accepted
// before it ends. A tick, a resident hit or a use that falls back reads its entry
// at acceptance, is updated in EXEC and gives its result from OUT; the next item is
// taken once that result is in the output register. A load without eviction adds
// the FIN state for the write of size and resident bit. A load that pushes the byte
// total above both watermarks runs eviction rounds: each round scans entries
// 1..ENTRIES-1, one per cycle through the entry and last-use memories, then drops the
// oldest candidate; rounds repeat until the total is at or below the low watermark
// or no candidate is left. Unload all walks the entry memory to clear the resident
// bits. A result waiting in the output register does not block acceptance; the next
// result waits until it has gone. The last-use memory needs no clearing: an unpinned
// resident entry always had its last use written when it was loaded.
module texture_residency_lru_budget
   import trlb_pkg::*;
#(
   parameter int unsigned ENTRIES = ENTRIES_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   trlb_req_if.sink   req,
   trlb_rsp_if.source rsp,
   trlb_csr_if.sink   csr
);
   localparam int unsigned AW = $clog2(ENTRIES);

   typedef struct packed {
      logic               loadable;
      logic               pinned;
      logic               resident;
      logic [BYTES_W-1:0] size;
   } entry_type;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXEC  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DROP  = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;
   localparam logic [2:0] ST_CLR   = 3'd6;
   localparam logic [2:0] ST_INIT  = 3'd7;

   logic [2:0] state_ff, state_in;

   logic [31:0] high_wm_ff, low_wm_ff;
   logic [2:0]  lim_mov_ff, lim_still_ff;
   logic [15:0] to_mov_ff, to_still_ff;

   logic               res0_ff;     // resident bit of entry 0, the fallback entry
   logic [TOTAL_W-1:0] total_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [2:0]         loads_ff, limit_ff;
   logic [15:0]        countdown_ff, timeout_ff;

   req_type            r_ff;
   logic               idx_ok;
   logic [AW-1:0]      idx;
   logic [AW-1:0]      scan_ff;     // address issued last cycle
   logic               scan_v_ff;   // read data valid for scan_ff
   logic               fwd_ff;      // entry 1 was dropped as the read of it was issued
   logic               found_ff;
   logic [AW-1:0]      best_ff;
   logic [TIME_W-1:0]  best_t_ff;
   logic [BYTES_W-1:0] best_sz_ff;
   logic               best_ld_ff;
   logic               keep_ld_ff, keep_pin_ff;
   logic [7:0]         evict_ff;
   logic               granted_ff, loaded_ff;
   rsp_type            out_ff;
   logic               out_v_ff, out_v_in, out_free;

   // memories
   logic               lu_we, ent_we;
   logic [AW-1:0]      lu_wa, ent_wa, rd_a;
   logic [TIME_W-1:0]  lu_wd, lu_rd;
   entry_type          ent_wd, ent_rd;

   trlb_ram #(.WIDTH(TIME_W), .DEPTH(ENTRIES)) u_last_used (
      .clock, .wr_en(lu_we), .wr_addr(lu_wa), .wr_data(lu_wd),
      .rd_addr(rd_a), .rd_data(lu_rd));
   trlb_ram #(.WIDTH($bits(entry_type)), .DEPTH(ENTRIES)) u_entry (
      .clock, .wr_en(ent_we), .wr_addr(ent_wa), .wr_data(ent_wd),
      .rd_addr(rd_a), .rd_data(ent_rd));

   assign idx_ok = (32'(r_ff.entry_index) < ENTRIES);
   assign idx    = AW'(r_ff.entry_index);

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = out_v_ff;
   assign rsp.data  = out_ff;
   assign csr.ready = 1'b1;

   assign out_free = !out_v_ff || rsp.ready;
   assign out_v_in = (state_ff == ST_OUT && out_free) ? 1'b1 :
                     (rsp.ready ? 1'b0 : out_v_ff);

   // scan 1..ENTRIES-1, clear 0..ENTRIES-1; the read of scan_ff arrives this cycle
   logic [AW-1:0] scan_next;
   logic          scan_last;
   assign scan_next = scan_ff + AW'(1);
   assign scan_last = (32'(scan_ff) == ENTRIES - 1);

   always_comb begin
      unique case (state_ff) inside
         ST_IDLE: rd_a = AW'(req.data.entry_index);
         ST_EXEC: rd_a = (r_ff.operation == OP_UNLOAD) ? '0 : AW'(1);
         ST_SCAN, ST_CLR: rd_a = scan_next;
         default: rd_a = AW'(1);
      endcase
   end

   logic cand;
   assign cand = scan_v_ff && ent_rd.resident && !ent_rd.pinned && (scan_ff != idx) &&
                 !(fwd_ff && scan_ff == AW'(1));

   // decisions in EXEC, on the entry read at acceptance
   logic use_load, do_load, load_try, load_fail, hit;
   assign use_load = (r_ff.operation == OP_USE) && idx_ok && ent_rd.loadable &&
                     !ent_rd.resident && (loads_ff < limit_ff);
   assign load_try = (r_ff.operation == OP_LOAD) && idx_ok && r_ff.make_resident &&
                     !ent_rd.resident;
   assign do_load   = (use_load || load_try) && r_ff.load_ok;
   assign load_fail = (use_load || load_try) && !r_ff.load_ok;
   assign hit       = idx_ok && ent_rd.loadable && (ent_rd.resident || do_load);

   logic [TOTAL_W:0]   sum;
   logic [TOTAL_W-1:0] sat_sum, drop_total;
   logic               evict_go;
   assign sum        = {1'b0, total_ff} + (TOTAL_W+1)'(r_ff.entry_bytes);
   assign sat_sum    = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
   assign evict_go   = (sat_sum > high_wm_ff) && (sat_sum > low_wm_ff);
   assign drop_total = (TOTAL_W'(best_sz_ff) > total_ff) ? '0 :
                       total_ff - TOTAL_W'(best_sz_ff);

   always_comb begin
      state_in = state_ff;
      lu_we = 1'b0; lu_wa = idx; lu_wd = r_ff.now_time;
      ent_we = 1'b0; ent_wa = idx; ent_wd = ent_rd;
      unique case (state_ff)
         ST_INIT: begin
            ent_we = 1'b1;
            ent_wa = scan_ff;
            ent_wd = '0;
            ent_wd.loadable = 1'b1;
            if (scan_last) state_in = ST_IDLE;
         end
         ST_IDLE: if (req.valid && req.ready) state_in = ST_EXEC;
         ST_EXEC: begin
            if (r_ff.operation == OP_UNLOAD) state_in = ST_CLR;
            else if (do_load && evict_go) state_in = ST_SCAN;
            else if (do_load) state_in = ST_FIN;
            else state_in = ST_OUT;
            if (r_ff.operation == OP_USE) begin
               if (hit) begin
                  lu_we = 1'b1;
               end else if (res0_ff) begin
                  lu_we = 1'b1; lu_wa = '0;
               end
            end
            if ((r_ff.operation == OP_USE || r_ff.operation == OP_LOAD) && idx_ok &&
                !do_load) begin
               ent_we = 1'b1;
               ent_wd.pinned = ent_rd.pinned | load_try;
               ent_wd.loadable = ent_rd.loadable & !load_fail;
            end
         end
         ST_SCAN: if (scan_last) state_in = ST_DROP;
         ST_DROP: begin
            if (found_ff) begin
               ent_we = 1'b1;
               ent_wa = best_ff;
               ent_wd.loadable = best_ld_ff;
               ent_wd.pinned = 1'b0;
               ent_wd.resident = 1'b0;
               ent_wd.size = best_sz_ff;
               if (drop_total > low_wm_ff) state_in = ST_SCAN;
               else state_in = ST_FIN;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            ent_we = 1'b1;
            ent_wd.loadable = keep_ld_ff;
            ent_wd.pinned = keep_pin_ff;
            ent_wd.resident = 1'b1;
            ent_wd.size = r_ff.entry_bytes;
            state_in = ST_OUT;
         end
         ST_OUT: if (out_free) state_in = ST_IDLE;
         ST_CLR: begin
            ent_we = 1'b1;
            ent_wa = scan_ff;
            ent_wd.resident = 1'b0;
            if (scan_last) state_in = ST_OUT;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         high_wm_ff   <= 32'd75497472;
         low_wm_ff    <= 32'd67108864;
         lim_mov_ff   <= 3'd1;
         lim_still_ff <= 3'd2;
         to_mov_ff    <= 16'd250;
         to_still_ff  <= 16'd50;
         res0_ff      <= 1'b0;
         total_ff     <= '0;
         count_ff     <= '0;
         loads_ff     <= '0;
         limit_ff     <= '0;
         countdown_ff <= '0;
         timeout_ff   <= '0;
         out_v_ff     <= 1'b0;
         scan_ff      <= '0;
         scan_v_ff    <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
         if (csr.valid && csr.ready) begin
            unique case (csr.data.index)
               REG_HIGH_WM:   high_wm_ff   <= csr.data.data;
               REG_LOW_WM:    low_wm_ff    <= csr.data.data;
               REG_LIM_MOV:   lim_mov_ff   <= csr.data.data[2:0];
               REG_LIM_STILL: lim_still_ff <= csr.data.data[2:0];
               REG_TO_MOV:    to_mov_ff    <= csr.data.data[15:0];
               REG_TO_STILL:  to_still_ff  <= csr.data.data[15:0];
               default: ;
            endcase
         end
         case (state_ff)
            ST_INIT: scan_ff <= scan_next;
            ST_IDLE: if (req.valid && req.ready) begin
               r_ff <= req.data;
            end
            ST_EXEC: begin
               evict_ff <= '0;
               loaded_ff <= do_load;
               scan_ff <= (r_ff.operation == OP_UNLOAD) ? '0 : AW'(1);
               scan_v_ff <= 1'b1;
               fwd_ff <= 1'b0;
               found_ff <= 1'b0;
               keep_ld_ff <= ent_rd.loadable;
               keep_pin_ff <= ent_rd.pinned | load_try;
               case (r_ff.operation)
                  OP_TICK: begin
                     limit_ff   <= r_ff.camera_moving ? lim_mov_ff : lim_still_ff;
                     timeout_ff <= r_ff.camera_moving ? to_mov_ff : to_still_ff;
                     if (r_ff.elapsed_ms >= countdown_ff) begin
                        countdown_ff <= '0;
                        loads_ff <= '0;
                     end else countdown_ff <= countdown_ff - r_ff.elapsed_ms;
                  end
                  OP_UNLOAD: begin
                     res0_ff <= 1'b0;
                     total_ff <= '0;
                     count_ff <= '0;
                  end
                  default: begin
                     if (do_load) begin
                        count_ff <= count_ff + CNT_W'(1);
                        total_ff <= sat_sum;
                     end
                     if (use_load && r_ff.load_ok) begin
                        if (loads_ff != 3'd7) loads_ff <= loads_ff + 3'd1;
                        countdown_ff <= timeout_ff;
                     end
                  end
               endcase
            end
            ST_SCAN: begin
               scan_ff <= scan_next;
               scan_v_ff <= !scan_last;
               fwd_ff <= 1'b0;
               if (cand && (!found_ff || lu_rd < best_t_ff)) begin
                  found_ff <= 1'b1;
                  best_ff <= scan_ff;
                  best_t_ff <= lu_rd;
                  best_sz_ff <= ent_rd.size;
                  best_ld_ff <= ent_rd.loadable;
               end
            end
            ST_DROP: begin
               if (found_ff) begin
                  total_ff <= drop_total;
                  if (count_ff != '0) count_ff <= count_ff - CNT_W'(1);
                  if (evict_ff != 8'd255) evict_ff <= evict_ff + 8'd1;
               end
               fwd_ff <= found_ff && (best_ff == AW'(1));
               scan_ff <= AW'(1);
               scan_v_ff <= 1'b1;
               found_ff <= 1'b0;
            end
            ST_FIN: if (idx == '0) res0_ff <= 1'b1;
            ST_CLR: scan_ff <= scan_next;
            default: ;
         endcase
      end
   end

   // result assembly reads the settled state in ST_OUT
   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         out_ff.granted <= granted_ff;
         out_ff.fallback <= (r_ff.operation == OP_USE) && !granted_ff;
         out_ff.loaded_now <= ((r_ff.operation == OP_USE) || (r_ff.operation == OP_LOAD))
                              && loaded_ff;
         out_ff.evicted_count <= ((r_ff.operation == OP_USE) ||
                                  (r_ff.operation == OP_LOAD)) ? evict_ff : 8'd0;
         out_ff.used_bytes <= total_ff;
         out_ff.resident_count <= count_ff;
      end
      if (state_ff == ST_EXEC)
         granted_ff <= (r_ff.operation == OP_USE) ? hit :
                       (r_ff.operation == OP_LOAD) ?
                          (idx_ok && (ent_rd.resident || do_load)) : 1'b0;
   end
endmodule
`default_nettype wire

// ----- tb/texture_residency_lru_budget_tb.sv -----
// Testbench for the texture residency tracker: directed table, random phases, scoreboard.
`default_nettype none
module texture_residency_lru_budget_tb;
   import trlb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned N_ENT = ENTRIES_DEFAULT;
   localparam int unsigned MAX_BYTES = 67108864;
   localparam int unsigned CYCLE_LIMIT = 100000000;

   logic clock;
   logic reset;

   trlb_req_if req_ch ();
   trlb_rsp_if rsp_ch ();
   trlb_csr_if csr_ch ();

   texture_residency_lru_budget i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // residency shadow state
   bit          sh_resident [N_ENT];
   bit          sh_pinned   [N_ENT];
   bit          sh_loadable [N_ENT];
   logic [31:0] sh_size     [N_ENT];
   logic [31:0] sh_last     [N_ENT];
   logic [31:0] sh_total;
   int unsigned sh_count;
   int unsigned sh_loads;
   logic [15:0] sh_window;
   logic [2:0]  sh_limit;
   logic [15:0] sh_timeout;
   logic [31:0] cf_high, cf_low;
   logic [2:0]  cf_lim_mov, cf_lim_still;
   logic [15:0] cf_to_mov, cf_to_still;

   rsp_type     pending_rsp [$];
   int unsigned errors;
   int unsigned cycles;
   int unsigned n_items, n_rsps, n_evicted, n_loaded, n_fallback;
   bit          idle_en;
   bit          rsp_hold;
   bit          hold_go;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("texture_residency_lru_budget_tb: errors");
            $finish;
         end
      end
   end

   task automatic report(input string what);
      errors++;
      $display("mismatch at cycle %0d: %s", cycles, what);
   endtask

   function automatic void shadow_reset();
      for (int i = 0; i < N_ENT; i++) begin
         sh_resident[i] = 0;
         sh_pinned[i] = 0;
         sh_loadable[i] = 1;
         sh_size[i] = 0;
         sh_last[i] = 0;
      end
      sh_total = 0; sh_count = 0; sh_loads = 0;
      sh_window = 0; sh_limit = 0; sh_timeout = 0;
      cf_high = 32'd75497472; cf_low = 32'd67108864;
      cf_lim_mov = 3'd1; cf_lim_still = 3'd2;
      cf_to_mov = 16'd250; cf_to_still = 16'd50;
   endfunction

   function automatic void shadow_config(input csr_type c);
      case (c.index)
         REG_HIGH_WM:   cf_high = c.data;
         REG_LOW_WM:    cf_low = c.data;
         REG_LIM_MOV:   cf_lim_mov = c.data[2:0];
         REG_LIM_STILL: cf_lim_still = c.data[2:0];
         REG_TO_MOV:    cf_to_mov = c.data[15:0];
         REG_TO_STILL:  cf_to_still = c.data[15:0];
         default: ;
      endcase
   endfunction

   // load one entry, evicting LRU unpinned entries past the high watermark
   function automatic bit load_entry(input int idx, input logic [31:0] nbytes, input bit ok,
                                     inout int unsigned evicted);
      logic [32:0] sum;
      int best;
      if (!ok) begin
         sh_loadable[idx] = 0;
         return 0;
      end
      sh_count++;
      sum = {1'b0, sh_total} + {1'b0, nbytes};
      sh_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      if (sh_total > cf_high) begin
         while (sh_total > cf_low) begin
            best = -1;
            for (int i = 1; i < N_ENT; i++)
               if (sh_resident[i] && !sh_pinned[i] && i != idx)
                  if (best < 0 || sh_last[i] < sh_last[best]) best = i;
            if (best < 0) break;
            sh_resident[best] = 0;
            sh_total = (sh_size[best] > sh_total) ? 32'd0 : sh_total - sh_size[best];
            if (sh_count > 0) sh_count--;
            if (evicted < 255) evicted++;
         end
      end
      sh_size[idx] = nbytes;
      sh_resident[idx] = 1;
      return 1;
   endfunction

   function automatic rsp_type residency_predict(input req_type r);
      rsp_type o;
      int unsigned ev;
      int idx;
      bit sel;
      ev = 0;
      idx = r.entry_index;
      o = '0;
      case (r.operation)
         OP_TICK: begin
            sh_limit = r.camera_moving ? cf_lim_mov : cf_lim_still;
            sh_timeout = r.camera_moving ? cf_to_mov : cf_to_still;
            if (r.elapsed_ms >= sh_window) begin
               sh_window = 0;
               sh_loads = 0;
            end else begin
               sh_window = sh_window - r.elapsed_ms;
            end
         end
         OP_USE: begin
            sel = 0;
            if (sh_loadable[idx]) begin
               if (sh_resident[idx]) begin
                  sel = 1;
               end else if (sh_loads < sh_limit) begin
                  if (load_entry(idx, {5'd0, r.entry_bytes}, r.load_ok, ev)) begin
                     sel = 1;
                     o.loaded_now = 1;
                     if (sh_loads < 7) sh_loads++;
                     sh_window = sh_timeout;
                  end
               end
            end
            if (sel) begin
               sh_last[idx] = r.now_time;
               o.granted = 1;
            end else begin
               o.fallback = 1;
               if (sh_resident[0]) sh_last[0] = r.now_time;
            end
         end
         OP_LOAD: begin
            if (r.make_resident && !sh_resident[idx]) begin
               sh_pinned[idx] = 1;
               if (load_entry(idx, {5'd0, r.entry_bytes}, r.load_ok, ev)) o.loaded_now = 1;
            end
            o.granted = sh_resident[idx];
         end
         default: begin
            for (int i = 0; i < N_ENT; i++) sh_resident[i] = 0;
            sh_total = 0;
            sh_count = 0;
         end
      endcase
      o.evicted_count = ev[7:0];
      o.used_bytes = sh_total;
      o.resident_count = (sh_count > 511) ? 9'd511 : sh_count[8:0];
      return o;
   endfunction

   // send one item; valid stays high after acceptance unless a gap follows
   task automatic send_item(input req_type r, input bit typed, input rsp_type typed_rsp);
      rsp_type p;
      if (idle_en && $urandom_range(99) < 34) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= r;
      do @(posedge clock); while (!req_ch.ready);
      p = residency_predict(r);
      pending_rsp.push_back(typed ? typed_rsp : p);
      n_items++;
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] index, input logic [31:0] value);
      csr_type c;
      c.index = index;
      c.data = value;
      csr_ch.valid <= 1'b1;
      csr_ch.data <= c;
      do @(posedge clock); while (!csr_ch.ready);
      shadow_config(c);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] hi, input logic [31:0] lo,
                            input logic [2:0] lm, input logic [2:0] ls,
                            input logic [15:0] tm, input logic [15:0] ts);
      drain();
      write_reg(REG_HIGH_WM, hi);
      write_reg(REG_LOW_WM, lo);
      write_reg(REG_LIM_MOV, {29'd0, lm});
      write_reg(REG_LIM_STILL, {29'd0, ls});
      write_reg(REG_TO_MOV, {16'd0, tm});
      write_reg(REG_TO_STILL, {16'd0, ts});
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // result side: random stalls, long hold on request, check against expected results
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !rsp_hold && !(idle_en && $urandom_range(99) < 34);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
               report("result with nothing expected");
            end else begin
               rsp_type e;
               e = pending_rsp.pop_front();
               n_rsps++;
               if (rsp_ch.data.granted !== e.granted)
                  report($sformatf("granted %b exp %b", rsp_ch.data.granted, e.granted));
               if (rsp_ch.data.fallback !== e.fallback)
                  report($sformatf("fallback %b exp %b", rsp_ch.data.fallback, e.fallback));
               if (rsp_ch.data.loaded_now !== e.loaded_now)
                  report($sformatf("loaded_now %b exp %b", rsp_ch.data.loaded_now,
                                   e.loaded_now));
               if (rsp_ch.data.evicted_count !== e.evicted_count)
                  report($sformatf("evicted_count %0d exp %0d",
                                   rsp_ch.data.evicted_count, e.evicted_count));
               if (rsp_ch.data.used_bytes !== e.used_bytes)
                  report($sformatf("used_bytes %0d exp %0d", rsp_ch.data.used_bytes,
                                   e.used_bytes));
               if (rsp_ch.data.resident_count !== e.resident_count)
                  report($sformatf("resident_count %0d exp %0d",
                                   rsp_ch.data.resident_count, e.resident_count));
               n_evicted += e.evicted_count;
               n_loaded += e.loaded_now;
               n_fallback += e.fallback;
            end
         end
      end
   end

   // long receiver hold-off, counted here
   initial begin
      rsp_hold = 1'b0;
      wait (hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (400) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   function automatic req_type mk(input logic [1:0] op, input int idx, input int unsigned nb,
                                  input bit ok, input bit pin, input bit mov,
                                  input int unsigned el, input logic [31:0] now);
      req_type r;
      r.operation = op;
      r.entry_index = idx[7:0];
      r.entry_bytes = nb[26:0];
      r.load_ok = ok;
      r.make_resident = pin;
      r.camera_moving = mov;
      r.elapsed_ms = el[15:0];
      r.now_time = now;
      return r;
   endfunction

   function automatic rsp_type mkr(input bit g, input bit f, input logic [31:0] used,
                                   input int unsigned cnt);
      rsp_type o;
      o = '0;
      o.granted = g;
      o.fallback = f;
      o.used_bytes = used;
      o.resident_count = cnt[8:0];
      return o;
   endfunction

   logic [31:0] clock_ms;

   function automatic req_type random_item();
      int unsigned pick;
      int idx;
      int unsigned nb;
      int unsigned el;
      pick = $urandom_range(99);
      idx = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(24);
      case ($urandom_range(19))
         0: nb = MAX_BYTES;
         1: nb = $urandom_range(MAX_BYTES);
         default: nb = $urandom_range(1 << 20);
      endcase
      el = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(300);
      clock_ms = ($urandom_range(49) == 0) ? $urandom : clock_ms + $urandom_range(0, 40);
      return mk(pick < 15 ? OP_TICK : pick < 72 ? OP_USE : pick < 97 ? OP_LOAD : OP_UNLOAD,
                idx, nb, $urandom_range(99) < 85, $urandom_range(1), $urandom_range(1),
                el, clock_ms);
   endfunction

   typedef struct {
      req_type stim;
      bit      typed;
      rsp_type want;
   } table_row_type;

   table_row_type dir_rows [$];

   initial begin
      rsp_type none;
      none = '0;
      errors = 0; n_items = 0; n_rsps = 0; n_evicted = 0; n_loaded = 0; n_fallback = 0;
      idle_en = 1'b1;
      hold_go = 1'b0;
      clock_ms = 0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      shadow_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows: reset state, extremes, special cases
      dir_rows = '{
         '{mk(OP_USE, 5, 100, 1, 0, 0, 0, 1), 1, mkr(0, 1, 0, 0)},
         '{mk(OP_LOAD, 7, 100, 1, 0, 0, 0, 2), 1, mkr(0, 0, 0, 0)},
         '{mk(OP_TICK, 0, 0, 0, 0, 0, 0, 3), 1, mkr(0, 0, 0, 0)},
         '{mk(OP_USE, 1, 1000, 1, 0, 0, 0, 10), 0, none},
         '{mk(OP_USE, 1, 1000, 1, 0, 0, 0, 11), 0, none},
         '{mk(OP_USE, 2, 500, 0, 0, 0, 0, 12), 0, none},
         '{mk(OP_USE, 2, 500, 1, 0, 0, 0, 13), 0, none},
         '{mk(OP_TICK, 0, 0, 0, 0, 1, 65535, 14), 0, none},
         '{mk(OP_USE, 2, 500, 1, 0, 0, 0, 15), 0, none},
         '{mk(OP_LOAD, 2, 700, 1, 1, 0, 0, 16), 0, none},
         '{mk(OP_LOAD, 3, 700, 0, 1, 0, 0, 17), 0, none},
         '{mk(OP_LOAD, 0, 30000000, 1, 1, 0, 0, 18), 0, none},
         '{mk(OP_TICK, 0, 0, 0, 0, 0, 65535, 19), 0, none},
         '{mk(OP_USE, 4, 20000000, 1, 0, 0, 0, 20), 0, none},
         '{mk(OP_USE, 255, MAX_BYTES, 1, 0, 0, 0, 32'hFFFF_FFFF), 0, none},
         '{mk(OP_USE, 9, 5, 1, 0, 0, 0, 21), 0, none},
         '{mk(OP_LOAD, 255, MAX_BYTES, 1, 1, 1, 0, 22), 0, none},
         '{mk(OP_LOAD, 250, 134217727 & 27'h2AAAAAA, 1, 1, 1, 65535, 23), 0, none},
         '{mk(OP_USE, 3, 1, 1, 0, 0, 0, 24), 0, none},
         '{mk(OP_UNLOAD, 0, 0, 0, 0, 0, 0, 25), 1, mkr(0, 0, 0, 0)},
         '{mk(OP_USE, 0, 1, 1, 0, 0, 0, 26), 0, none},
         '{mk(OP_TICK, 0, 0, 0, 0, 1, 1, 27), 0, none},
         '{mk(OP_USE, 6, 27'h5555555 & 27'h3FFFFFF, 1, 0, 0, 0, 28), 0, none}
      };
      foreach (dir_rows[k]) send_item(dir_rows[k].stim, dir_rows[k].typed, dir_rows[k].want);

      // random phases across register settings
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: configure(32'd4000000, 32'd3000000, 3'd7, 3'd7, 16'd100, 16'd30);
            1: configure(32'd0, 32'd0, 3'd1, 3'd2, 16'd0, 16'd0);
            2: configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0, 3'd7, 16'd65535, 16'd65535);
            3: configure(32'd2000000, 32'd0, 3'd3, 3'd0, 16'd20, 16'd500);
            default: configure(32'd6000000, 32'd5000000, 3'd7, 3'd5, 16'd65535, 16'd0);
         endcase
         idle_en = (ph != 2);
         for (int n = 0; n < 110; n++) begin
            if (ph == 3 && n == 10) hold_go = 1'b1;
            send_item(random_item(), 0, none);
         end
         idle_en = 1'b1;
      end

      req_ch.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d items, %0d results: %0d loads, %0d evictions, %0d fallbacks",
               n_items, n_rsps, n_loaded, n_evicted, n_fallback);
      $display("five register settings incl. zero and full-scale watermarks, one long stall");
      if (errors == 0) begin
         $display("texture_residency_lru_budget_tb: clean");
      end else begin
         $display("texture_residency_lru_budget_tb: errors");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ----- filelist.f -----
hw/rtl/trlb_pkg.sv
hw/rtl/trlb_if.sv
hw/rtl/trlb_ram.sv
hw/rtl/texture_residency_lru_budget.sv
tb/texture_residency_lru_budget_tb.sv
